// ----- rtl/srl_hs_pkg.sv -----
// shared types, constants and helpers for the serial rumble link handshake core
// no dependencies; used by srl_hs_step, srl_hs_out_reg and the top level

package srl_hs_pkg;

  // handshake stage codes
  localparam logic [2:0] PH_IDENT   = 3'd0;
  localparam logic [2:0] PH_CONF1   = 3'd1;
  localparam logic [2:0] PH_CONF2   = 3'd2;
  localparam logic [2:0] PH_POLL    = 3'd3;
  localparam logic [2:0] PH_RESYNC  = 3'd4;

  // number of identification words
  localparam logic [2:0] ID_COUNT   = 3'd4;

  // protocol words
  localparam logic [15:0] START_LOW  = 16'h8002;
  localparam logic [15:0] DONE_HIGH  = 16'h8000;
  localparam logic [31:0] CONF1_WORD = 32'h1000_0010;
  localparam logic [31:0] CONF2_WORD = 32'h2000_0013;
  localparam logic [31:0] OFF_WORD   = 32'h4000_0004;
  localparam logic [31:0] POLL_WORD  = 32'h3000_0003;
  localparam logic [31:0] ON_WORD    = 32'h4000_0026;

  // rumble polls answered with rumble-on after a request
  localparam logic [1:0] HOLD_POLLS  = 2'd2;

  // one processed transaction, handed from the step logic to the output register
  typedef struct packed {
    logic        load;
    logic        has_tx;
    logic [31:0] tx_word;
  } step_res_t;

  // fixed identification words
  function automatic logic [15:0] id_word(input logic [1:0] idx);
    logic [15:0] w;
    case (idx)
      2'd0:    w = 16'h494E;
      2'd1:    w = 16'h544E;
      2'd2:    w = 16'h4E45;
      default: w = 16'h4F44;
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/srl_hs_step.sv -----
// handshake state registers and the single-pass next-state and answer logic
// depends on srl_hs_pkg

module srl_hs_step (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  go_i,
  input  logic [31:0]           rx_word_i,
  input  logic                  rumble_request_i,
  output srl_hs_pkg::step_res_t res_o
);

  logic [2:0]  phase_r, phase_nxt;
  logic [2:0]  id_index_r, id_index_nxt;
  logic [15:0] sent_high_r, sent_high_nxt;
  logic [15:0] sent_low_r, sent_low_nxt;
  logic [1:0]  hold_count_r, hold_count_nxt;
  logic        has_tx;
  logic [31:0] tx_word;
  logic [15:0] rx_hi;
  logic [15:0] rx_lo;
  logic [2:0]  idx_v;
  logic [1:0]  hold_v;

  assign rx_hi = rx_word_i[31:16];
  assign rx_lo = rx_word_i[15:0];

  // next state and answer for the transaction in the input register
  always_comb begin
    phase_nxt      = phase_r;
    id_index_nxt   = id_index_r;
    sent_high_nxt  = sent_high_r;
    sent_low_nxt   = sent_low_r;
    hold_count_nxt = hold_count_r;
    has_tx         = 1'b1;
    tx_word        = '0;
    idx_v          = id_index_r;
    hold_v         = hold_count_r;
    case (phase_r)
      srl_hs_pkg::PH_IDENT: begin
        if (rx_hi == sent_low_r) begin
          if (id_index_r < srl_hs_pkg::ID_COUNT) begin
            if (rx_word_i == ~{sent_high_r, sent_low_r}) begin
              idx_v = 3'(id_index_r + 3'd1);
            end
          end
        end else begin
          idx_v = '0;
        end
        if ((rx_hi == sent_low_r) && (id_index_r >= srl_hs_pkg::ID_COUNT) &&
            (rx_lo == srl_hs_pkg::START_LOW)) begin
          phase_nxt = srl_hs_pkg::PH_CONF1;
          tx_word   = srl_hs_pkg::CONF1_WORD;
        end else begin
          id_index_nxt  = idx_v;
          sent_high_nxt = (idx_v < srl_hs_pkg::ID_COUNT) ?
                          srl_hs_pkg::id_word(idx_v[1:0]) : srl_hs_pkg::DONE_HIGH;
          sent_low_nxt  = ~rx_lo;
          tx_word       = {sent_high_nxt, sent_low_nxt};
        end
      end
      srl_hs_pkg::PH_CONF1: begin
        if (rx_word_i == srl_hs_pkg::CONF1_WORD) begin
          tx_word   = srl_hs_pkg::CONF2_WORD;
          phase_nxt = srl_hs_pkg::PH_CONF2;
        end else begin
          phase_nxt = srl_hs_pkg::PH_RESYNC;
        end
      end
      srl_hs_pkg::PH_CONF2: begin
        if (rx_word_i == srl_hs_pkg::CONF2_WORD) begin
          tx_word   = srl_hs_pkg::OFF_WORD;
          phase_nxt = srl_hs_pkg::PH_POLL;
        end else begin
          phase_nxt = srl_hs_pkg::PH_RESYNC;
        end
      end
      srl_hs_pkg::PH_POLL: begin
        if (rx_word_i == srl_hs_pkg::POLL_WORD) begin
          hold_v = rumble_request_i ? srl_hs_pkg::HOLD_POLLS : hold_count_r;
          if (hold_v != 2'd0) begin
            hold_count_nxt = 2'(hold_v - 2'd1);
            tx_word        = srl_hs_pkg::ON_WORD;
          end else begin
            hold_count_nxt = hold_v;
            tx_word        = srl_hs_pkg::OFF_WORD;
          end
        end else begin
          phase_nxt = srl_hs_pkg::PH_RESYNC;
        end
      end
      default: begin
        // resync, also taken by codes that never arise
        phase_nxt     = srl_hs_pkg::PH_IDENT;
        id_index_nxt  = '0;
        sent_high_nxt = '0;
        sent_low_nxt  = '0;
        has_tx        = 1'b0;
      end
    endcase
  end

  // state registers advance once per processed transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= srl_hs_pkg::PH_IDENT;
      id_index_r   <= '0;
      sent_high_r  <= '0;
      sent_low_r   <= '0;
      hold_count_r <= '0;
    end else if (go_i) begin
      phase_r      <= phase_nxt;
      id_index_r   <= id_index_nxt;
      sent_high_r  <= sent_high_nxt;
      sent_low_r   <= sent_low_nxt;
      hold_count_r <= hold_count_nxt;
    end
  end

  assign res_o.load    = go_i;
  assign res_o.has_tx  = has_tx;
  assign res_o.tx_word = tx_word;

  // identification index never passes the word count
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    id_index_r <= srl_hs_pkg::ID_COUNT)
    else $error("id index out of range");

  // rumble hold never exceeds the poll count
  a_hold_range: assert property (@(posedge clk) disable iff (!rst_n)
    hold_count_r <= srl_hs_pkg::HOLD_POLLS)
    else $error("hold count out of range");

  // only the five real stages are ever reached
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= srl_hs_pkg::PH_RESYNC)
    else $error("unused stage code reached");

  // a resync step sends nothing and returns to identification with cleared identification state
  a_resync: assert property (@(posedge clk) disable iff (!rst_n)
    (go_i && phase_r == srl_hs_pkg::PH_RESYNC) |->
      (!has_tx ##1 (phase_r == srl_hs_pkg::PH_IDENT && id_index_r == 3'd0 &&
                    sent_low_r == 16'd0)))
    else $error("resync step misbehaved");

  // hold count changes only on a processed poll
  a_hold_only_poll: assert property (@(posedge clk) disable iff (!rst_n)
    !(go_i && phase_r == srl_hs_pkg::PH_POLL) |=> $stable(hold_count_r))
    else $error("hold count changed outside a poll");

endmodule

// ----- rtl/srl_hs_out_reg.sv -----
// output register holding the answer word until the receiver takes it
// depends on srl_hs_pkg

module srl_hs_out_reg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  srl_hs_pkg::step_res_t res_i,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [31:0]           out_tx_word
);

  logic        valid_r;
  logic [31:0] word_r;

  // control: load on a processed transaction, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_i.load) begin
      valid_r <= res_i.has_tx;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (res_i.load && res_i.has_tx) begin
      word_r <= res_i.tx_word;
    end
  end

  assign out_valid   = valid_r;
  assign out_tx_word = word_r;

endmodule

// ----- rtl/serial_rumble_link_handshake_core.sv -----
// serial rumble link handshake: input register, step logic and output register
// depends on srl_hs_pkg, srl_hs_step and srl_hs_out_reg
//
// Usage:
//   Input channel in_valid/in_ready carries one received serial word
//   (in_rx_word) and the software rumble request (in_rumble_request).
//   Result channel out_valid/out_ready carries the word to send next
//   (out_tx_word); each result transaction starts one serial transfer.
//   A received word produces zero or one result: the resync step that
//   follows a mismatch produces none.
//   An accepted transaction passes the input register, then the output
//   register, before it is answered.
//   Throughput: one transaction per cycle while out_ready stays high; all work
//   is one pass of compare and select logic between input and output registers.
//   Stall: while out_ready is low and a result waits, the transaction in
//   the input register holds and in_ready falls once that register is full.
//   Reset (rst_n low, synchronous): clears the handshake stage, the
//   identification progress, the last answer and the rumble hold, and
//   empties both registers.

module serial_rumble_link_handshake_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_rx_word,
  input  logic        in_rumble_request,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_tx_word
);

  logic                  stg_valid_r;
  logic [31:0]           stg_rx_word_r;
  logic                  stg_req_r;
  logic                  go;
  srl_hs_pkg::step_res_t res;

  // process when the output register is free or being emptied
  assign go       = stg_valid_r && (!out_valid || out_ready);
  assign in_ready = !stg_valid_r || go;

  // input register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_ready) begin
      stg_valid_r <= in_valid;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_rx_word_r <= in_rx_word;
      stg_req_r     <= in_rumble_request;
    end
  end

  srl_hs_step u_step (
    .clk              (clk),
    .rst_n            (rst_n),
    .go_i             (go),
    .rx_word_i        (stg_rx_word_r),
    .rumble_request_i (stg_req_r),
    .res_o            (res)
  );

  srl_hs_out_reg u_out_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_i       (res),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_tx_word (out_tx_word)
  );

endmodule

// ----- tb/sv/rumble_link_tb_pkg.sv -----
`timescale 1ns / 1ps
// scoreboard for the serial rumble link handshake core: follows the handshake
// and queues the tx word each received transaction should produce
// depends on srl_hs_pkg

package rumble_link_tb_pkg;
  import srl_hs_pkg::*;

  // identification words answered in order during the ident stage
  localparam logic [15:0] ID_WORDS [4] = '{16'h494E, 16'h544E, 16'h4E45, 16'h4F44};

  class rumble_link_scoreboard;
    logic [2:0]  phase;
    logic [2:0]  id_index;
    logic [15:0] sent_high;
    logic [15:0] sent_low;
    logic [1:0]  hold_count;
    logic [31:0] tx_expected_q[$];
    int          errors;

    function new();
      phase      = PH_IDENT;
      id_index   = 3'd0;
      sent_high  = 16'h0000;
      sent_low   = 16'h0000;
      hold_count = 2'd0;
      errors     = 0;
    endfunction

    // advance the handshake by one received word, queue the answer if any
    function void note_input(logic [31:0] rx, logic req);
      logic [15:0] rx_hi;
      logic [15:0] rx_lo;
      rx_hi = rx[31:16];
      rx_lo = rx[15:0];
      case (phase)
        PH_IDENT: begin
          if (rx_hi != sent_low) begin
            id_index = 3'd0;
          end else if (id_index < ID_COUNT) begin
            if (rx == ~{sent_high, sent_low}) id_index = id_index + 3'd1;
          end else if (rx_lo == START_LOW) begin
            phase = PH_CONF1;
            tx_expected_q.push_back(CONF1_WORD);
            return;
          end
          sent_high = (id_index < ID_COUNT) ? ID_WORDS[id_index[1:0]] : DONE_HIGH;
          sent_low  = ~rx_lo;
          tx_expected_q.push_back({sent_high, sent_low});
        end
        PH_CONF1: begin
          if (rx == CONF1_WORD) begin
            phase = PH_CONF2;
            tx_expected_q.push_back(CONF2_WORD);
          end else begin
            phase = PH_RESYNC;
            tx_expected_q.push_back(32'h0);
          end
        end
        PH_CONF2: begin
          if (rx == CONF2_WORD) begin
            phase = PH_POLL;
            tx_expected_q.push_back(OFF_WORD);
          end else begin
            phase = PH_RESYNC;
            tx_expected_q.push_back(32'h0);
          end
        end
        PH_POLL: begin
          if (rx == POLL_WORD) begin
            if (req) hold_count = HOLD_POLLS;
            if (hold_count != 2'd0) begin
              hold_count = hold_count - 2'd1;
              tx_expected_q.push_back(ON_WORD);
            end else begin
              tx_expected_q.push_back(OFF_WORD);
            end
          end else begin
            phase = PH_RESYNC;
            tx_expected_q.push_back(32'h0);
          end
        end
        default: begin
          // resync: no answer, rumble hold survives
          phase     = PH_IDENT;
          id_index  = 3'd0;
          sent_high = 16'h0000;
          sent_low  = 16'h0000;
        end
      endcase
    endfunction

    // compare one sent word with the oldest queued answer
    function void check_result(logic [31:0] tx);
      logic [31:0] want;
      if (tx_expected_q.size() == 0) begin
        $display("%0t: tx_word expected none actual %h", $time, tx);
        errors++;
        return;
      end
      want = tx_expected_q.pop_front();
      if (tx !== want) begin
        $display("%0t: tx_word expected %h actual %h", $time, want, tx);
        errors++;
      end
    endfunction
  endclass

endpackage

// ----- tb/sv/serial_rumble_link_handshake_core_test.sv -----
`timescale 1ns / 1ps
// testbench for serial_rumble_link_handshake_core: directed handshake walk, then
// random word streams with random idling on both channels
// depends on srl_hs_pkg, rumble_link_tb_pkg and the core RTL

module serial_rumble_link_handshake_core_test;
  import srl_hs_pkg::*;
  import rumble_link_tb_pkg::*;

  localparam int RANDOM_WORDS = 450;
  localparam int STALL_LIMIT  = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_rx_word = 32'h0;
  logic        in_rumble_request = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_tx_word;

  bit calm = 1'b0;
  int stall_cycles = 0;
  rumble_link_scoreboard sb = new();

  serial_rumble_link_handshake_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_word        (in_rx_word),
    .in_rumble_request (in_rumble_request),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_tx_word       (out_tx_word)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // pick the next partner word from the tracked handshake, with some noise
  function automatic logic [31:0] partner_word(bit clean);
    logic [31:0] w;
    int          noise_pct;
    w = $urandom;
    case (sb.phase)
      PH_IDENT:           noise_pct = 4;
      PH_CONF1, PH_CONF2: noise_pct = 6;
      PH_POLL:            noise_pct = 10;
      default:            noise_pct = 100;
    endcase
    if (!clean && $urandom_range(0, 99) < noise_pct) begin
      // half the noise keeps the high half in step so only the low half breaks
      if ($urandom_range(0, 1) == 1) w[31:16] = sb.sent_low;
      return w;
    end
    case (sb.phase)
      PH_IDENT: begin
        if (sb.id_index >= ID_COUNT)
          w = {sb.sent_low, ($urandom_range(0, 7) == 0) ? w[15:0] : START_LOW};
        else if (sb.sent_low == ~sb.sent_high)
          w = ~{sb.sent_high, sb.sent_low};
        else
          w = {sb.sent_low, ID_WORDS[sb.id_index[1:0]]};
      end
      PH_CONF1: w = CONF1_WORD;
      PH_CONF2: w = CONF2_WORD;
      PH_POLL:  w = POLL_WORD;
      default:  ;
    endcase
    return w;
  endfunction

  // offer one received word and wait for its transaction
  task automatic send_word(input logic [31:0] rx, input logic req);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_rx_word        <= rx;
    in_rumble_request <= req;
    do @(posedge clk); while (!(in_valid && in_ready));
    sb.note_input(rx, req);
  endtask

  // main stimulus
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes and a start code before identification is done
    send_word(32'h0000_0000, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b1);
    send_word({sb.sent_low, START_LOW}, 1'b0);
    // clean walk through identification and confirmation
    while (sb.phase != PH_POLL) send_word(partner_word(1'b1), 1'b0);
    // rumble request, hold running out, request again
    send_word(POLL_WORD, 1'b1);
    send_word(POLL_WORD, 1'b0);
    send_word(POLL_WORD, 1'b0);
    send_word(POLL_WORD, 1'b1);
    // broken poll, then the silent resync word
    send_word(32'h3000_0002, 1'b0);
    send_word(POLL_WORD, 1'b1);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS / 2) begin
        // hold the sender until every answer is out
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.tx_expected_q.size() != 0);
      end
      if (i == RANDOM_WORDS - 60) calm = 1'b1;
      send_word(partner_word(1'b0), $urandom_range(0, 3) == 0);
    end
    in_valid <= 1'b0;

    while (sb.tx_expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.tx_expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // result side back-pressure in random bursts
  initial begin
    while (!rst_n) @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  // check every sent word
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_tx_word);
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule

// ----- serial_rumble_link_handshake_core.f -----
rtl/srl_hs_pkg.sv
rtl/srl_hs_step.sv
rtl/srl_hs_out_reg.sv
rtl/serial_rumble_link_handshake_core.sv
tb/sv/rumble_link_tb_pkg.sv
tb/sv/serial_rumble_link_handshake_core_test.sv
